// ----- hdl/puf_pkg.sv -----
// ----------------------------------------------------------------------------
// puf_pkg
// Shared types and constants of the percolation union-find core.
// ----------------------------------------------------------------------------
package puf_pkg;

    localparam int unsigned SIDE_DEFAULT = 64;
    localparam int unsigned IW           = 12;  // site index width
    localparam int unsigned CW           = 13;  // open count width

    // Source of the next value of the node being walked toward its root.
    typedef enum logic [2:0] {
        NS_HOLD,
        NS_NB,
        NS_SITE,
        NS_TOP,
        NS_BOT,
        NS_PARENT
    } node_src_t;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       row;
        logic       col;
        logic       rd_open_site;
        logic       set_open;
        logic       nb_sel;
        logic [1:0] k;
        node_src_t  node_src;
        logic       save_a;
        logic       save_b;
        logic       rd_parent;
        logic       rd_wa;
        logic       rd_wb;
        logic       link;
        logic       push;
    } puf_cmd_t;

    typedef struct packed {
        logic clr_last;
        logic site_ok;
        logic open_q;
        logic nb_exists;
        logic nb_check;
        logic is_root;
        logic root_eq;
        logic out_free;
    } puf_sts_t;

endpackage

// ----- hdl/puf_dpath.sv -----
// ----------------------------------------------------------------------------
// puf_dpath
// Open map, parent and weight memories, neighbor logic and result register.
// ----------------------------------------------------------------------------
module puf_dpath #(
    parameter int unsigned SIDE = puf_pkg::SIDE_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  puf_pkg::puf_cmd_t     cmd,
    output puf_pkg::puf_sts_t     sts,
    input  logic [puf_pkg::IW-1:0] site_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic                  newly_opened,
    output logic [puf_pkg::CW-1:0] open_count,
    output logic                  percolates,
    output logic                  stop
);
    import puf_pkg::*;

    localparam int unsigned NSITE = SIDE * SIDE;
    localparam int unsigned NNODE = NSITE + 2;
    localparam int unsigned NW    = $clog2(NNODE);
    localparam int unsigned OW    = $clog2(NSITE);
    localparam int unsigned WW    = $clog2(NNODE + 1);
    localparam int unsigned CLW   = $clog2(SIDE);
    localparam int unsigned RSH   = 24;
    localparam int unsigned RW    = 25;
    localparam longint unsigned RECIP = (64'd1 << RSH) / SIDE;
    localparam int unsigned PW    = IW + RW;
    localparam int unsigned SDW   = $clog2(SIDE + 1);
    localparam int unsigned MW    = IW + SDW + 1;

    logic            open_mem [NSITE];
    logic [NW-1:0]   par_mem  [NNODE];
    logic [WW-1:0]   wt_mem   [NNODE];

    logic [IW-1:0]   r_reg;
    logic [IW-1:0]   row_reg;
    logic [CLW-1:0]  col_reg;
    logic [NW-1:0]   node_reg, ra_reg, rb_reg, clr_reg;
    logic [WW-1:0]   wa_reg, w_q_reg;
    logic [NW-1:0]   par_q_reg;
    logic            open_q_reg;
    logic [CW-1:0]   count_reg;
    logic            fresh_reg;
    logic            out_valid_reg, newly_reg, perc_reg, stop_reg;
    logic [CW-1:0]   cnt_out_reg;

    logic [NW-1:0]   rn, nb_node, node_next;
    logic [PW-1:0]   prod;
    logic [MW-1:0]   rem;
    logic            top_row, bot_row;
    logic [WW-1:0]   wsum;
    logic            perc;
    logic            nb_exists, nb_check;

    assign rn      = NW'(r_reg);
    assign prod    = PW'(r_reg) * PW'(RECIP[RW-1:0]);
    assign rem     = MW'(r_reg) - MW'(row_reg * SIDE);
    assign top_row = 32'(r_reg) < SIDE;
    assign bot_row = (32'(r_reg) + SIDE) >= NSITE;
    assign wsum    = wa_reg + w_q_reg;
    assign perc    = ra_reg == rb_reg;

    // Neighbor chosen by the step number: above, below, left, right.
    always_comb
    begin
        nb_node   = rn;
        nb_exists = 1'b1;
        nb_check  = 1'b1;
        case (cmd.k)
            2'd0:
            begin
                nb_node  = top_row ? NW'(NSITE) : rn - NW'(SIDE);
                nb_check = !top_row;
            end
            2'd1:
            begin
                nb_node  = bot_row ? NW'(NSITE + 1) : rn + NW'(SIDE);
                nb_check = !bot_row;
            end
            2'd2:
            begin
                nb_node   = rn - NW'(1);
                nb_exists = col_reg != '0;
            end
            default:
            begin
                nb_node   = rn + NW'(1);
                nb_exists = 32'(col_reg) < SIDE - 1;
            end
        endcase
    end

    always_comb
    begin
        case (cmd.node_src)
            NS_NB:     node_next = nb_node;
            NS_SITE:   node_next = rn;
            NS_TOP:    node_next = NW'(NSITE);
            NS_BOT:    node_next = NW'(NSITE + 1);
            NS_PARENT: node_next = par_q_reg;
            default:   node_next = node_reg;
        endcase
    end

    assign sts.clr_last  = 32'(clr_reg) == NNODE - 1;
    assign sts.site_ok   = 32'(r_reg) < NSITE;
    assign sts.open_q    = open_q_reg;
    assign sts.nb_exists = nb_exists;
    assign sts.nb_check  = nb_check;
    assign sts.is_root   = par_q_reg == node_reg;
    assign sts.root_eq   = node_reg == ra_reg;
    assign sts.out_free  = !out_valid_reg || out_ready;

    // Memories: one write and one registered read each per cycle.
    always_ff @(posedge clk)
    begin
        if (cmd.clr)
        begin
            par_mem[clr_reg] <= clr_reg;
            wt_mem[clr_reg]  <= WW'(1);
            if (32'(clr_reg) < NSITE)
                open_mem[OW'(clr_reg)] <= 1'b0;
        end
        if (cmd.set_open)
            open_mem[OW'(r_reg)] <= 1'b1;
        if (cmd.rd_open_site)
            open_q_reg <= open_mem[OW'(r_reg)];
        else if (cmd.nb_sel && nb_check && nb_exists)
            open_q_reg <= open_mem[OW'(nb_node)];
        if (cmd.rd_parent)
            par_q_reg <= par_mem[node_reg];
        if (cmd.rd_wa)
            w_q_reg <= wt_mem[ra_reg];
        else if (cmd.rd_wb)
            w_q_reg <= wt_mem[rb_reg];
        if (cmd.link)
        begin
            if (wa_reg < w_q_reg)
            begin
                par_mem[ra_reg] <= rb_reg;
                wt_mem[rb_reg]  <= wsum;
            end
            else
            begin
                par_mem[rb_reg] <= ra_reg;
                wt_mem[ra_reg]  <= wsum;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            r_reg <= site_index;
        if (cmd.row)
            row_reg <= prod[RSH +: IW];
        if (cmd.col)
            col_reg <= (32'(rem) >= SIDE) ? CLW'(32'(rem) - SIDE) : CLW'(rem);
        node_reg <= node_next;
        if (cmd.save_a)
            ra_reg <= node_reg;
        if (cmd.save_b)
            rb_reg <= node_reg;
        if (cmd.rd_wb)
            wa_reg <= w_q_reg;
        if (cmd.push)
        begin
            newly_reg   <= fresh_reg;
            cnt_out_reg <= count_reg;
            perc_reg    <= perc;
            stop_reg    <= perc && ((32'(count_reg) << 1) > NSITE);
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg       <= '0;
            count_reg     <= '0;
            fresh_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.clr)
                clr_reg <= clr_reg + NW'(1);
            if (cmd.load)
                fresh_reg <= 1'b0;
            if (cmd.set_open)
            begin
                fresh_reg <= 1'b1;
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.push)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign newly_opened = newly_reg;
    assign open_count   = cnt_out_reg;
    assign percolates   = perc_reg;
    assign stop         = stop_reg;

    a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> (!out_valid_reg || out_ready))
        else $error("result pushed over an unread result");
    a_link_distinct: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> (ra_reg != rb_reg))
        else $error("link of two equal roots");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= NSITE)
        else $error("open count beyond site count");
    a_fresh_set: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.set_open |=> fresh_reg)
        else $error("newly opened flag lost");

endmodule

// ----- hdl/puf_ctrl.sv -----
// ----------------------------------------------------------------------------
// puf_ctrl
// Sequencer: clearing pass, site check, up to four joins and the percolation check.
// ----------------------------------------------------------------------------
module puf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  puf_pkg::puf_sts_t sts,
    output puf_pkg::puf_cmd_t cmd
);
    import puf_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_ROW, S_COL, S_RD_SITE, S_CHK_SITE, S_NB_SEL,
        S_NB_CHK, S_FIND_RD, S_FIND_CHK, S_W_RDA, S_W_RDB, S_W_LINK, S_PUSH
    } state_t;

    typedef enum logic [1:0] { PH_JA, PH_JB, PH_PT, PH_PB } phase_t;

    state_t     state_reg, state_next;
    phase_t     phase_reg, phase_next;
    logic [1:0] k_reg, k_next;

    always_comb
    begin
        cmd        = '0;
        cmd.k      = k_reg;
        cmd.node_src = NS_HOLD;
        state_next = state_reg;
        phase_next = phase_reg;
        k_next     = k_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clr = 1'b1;
                if (sts.clr_last)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_ROW;
                end
            end
            S_ROW:
            begin
                cmd.row    = 1'b1;
                state_next = S_COL;
            end
            S_COL:
            begin
                cmd.col    = 1'b1;
                state_next = S_RD_SITE;
            end
            S_RD_SITE:
            begin
                if (sts.site_ok)
                begin
                    cmd.rd_open_site = 1'b1;
                    state_next       = S_CHK_SITE;
                end
                else
                begin
                    cmd.node_src = NS_TOP;
                    phase_next   = PH_PT;
                    state_next   = S_FIND_RD;
                end
            end
            S_CHK_SITE:
            begin
                if (sts.open_q)
                begin
                    cmd.node_src = NS_TOP;
                    phase_next   = PH_PT;
                    state_next   = S_FIND_RD;
                end
                else
                begin
                    cmd.set_open = 1'b1;
                    k_next       = 2'd0;
                    state_next   = S_NB_SEL;
                end
            end
            S_NB_SEL:
            begin
                cmd.nb_sel   = 1'b1;
                cmd.node_src = NS_NB;
                phase_next   = PH_JA;
                if (!sts.nb_exists)
                begin
                    if (k_reg == 2'd3)
                    begin
                        cmd.node_src = NS_TOP;
                        phase_next   = PH_PT;
                        state_next   = S_FIND_RD;
                    end
                    else
                        k_next = k_reg + 2'd1;
                end
                else if (sts.nb_check)
                    state_next = S_NB_CHK;
                else
                    state_next = S_FIND_RD;
            end
            S_NB_CHK:
            begin
                if (sts.open_q)
                    state_next = S_FIND_RD;
                else if (k_reg == 2'd3)
                begin
                    cmd.node_src = NS_TOP;
                    phase_next   = PH_PT;
                    state_next   = S_FIND_RD;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_NB_SEL;
                end
            end
            S_FIND_RD:
            begin
                cmd.rd_parent = 1'b1;
                state_next    = S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                state_next = S_FIND_RD;
                if (!sts.is_root)
                    cmd.node_src = NS_PARENT;
                else
                begin
                    unique case (phase_reg)
                        PH_JA:
                        begin
                            cmd.save_a   = 1'b1;
                            cmd.node_src = NS_SITE;
                            phase_next   = PH_JB;
                        end
                        PH_JB:
                        begin
                            cmd.save_b = 1'b1;
                            if (!sts.root_eq)
                                state_next = S_W_RDA;
                            else if (k_reg == 2'd3)
                            begin
                                cmd.node_src = NS_TOP;
                                phase_next   = PH_PT;
                            end
                            else
                            begin
                                k_next     = k_reg + 2'd1;
                                state_next = S_NB_SEL;
                            end
                        end
                        PH_PT:
                        begin
                            cmd.save_a   = 1'b1;
                            cmd.node_src = NS_BOT;
                            phase_next   = PH_PB;
                        end
                        default:
                        begin
                            cmd.save_b = 1'b1;
                            state_next = S_PUSH;
                        end
                    endcase
                end
            end
            S_W_RDA:
            begin
                cmd.rd_wa  = 1'b1;
                state_next = S_W_RDB;
            end
            S_W_RDB:
            begin
                cmd.rd_wb  = 1'b1;
                state_next = S_W_LINK;
            end
            S_W_LINK:
            begin
                cmd.link = 1'b1;
                if (k_reg == 2'd3)
                begin
                    cmd.node_src = NS_TOP;
                    phase_next   = PH_PT;
                    state_next   = S_FIND_RD;
                end
                else
                begin
                    k_next     = k_reg + 2'd1;
                    state_next = S_NB_SEL;
                end
            end
            S_PUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.push   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            phase_reg <= PH_JA;
            k_reg     <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            k_reg     <= k_next;
        end
    end

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CLEAR) |-> !in_ready)
        else $error("input taken during clearing pass");
    a_link_follows_reads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.link |-> ($past(cmd.rd_wb) && $past(cmd.rd_wa, 2)))
        else $error("link without both weights read");
    a_load_then_push: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> !cmd.push)
        else $error("result pushed right after load");

endmodule

// ----- hdl/percolation_union_find_core.sv -----
// ----------------------------------------------------------------------------
// percolation_union_find_core
// Opens grid sites and tracks top-to-bottom connectivity by weighted union.
// ----------------------------------------------------------------------------
// An out-of-range site and one already open go straight to the top and bottom
// root walks. A new site tests each neighbor in turn and, when joined, walks both
// roots and, if they differ, reads the two weights and links them.
// One beat at a time: the next is taken the cycle after the result is pushed.
// Reset starts a clearing pass over all SIDE*SIDE+2 nodes; no beat is taken before.
module percolation_union_find_core #(
    parameter int unsigned SIDE = puf_pkg::SIDE_DEFAULT
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [puf_pkg::IW-1:0] site_index,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   newly_opened,
    output logic [puf_pkg::CW-1:0] open_count,
    output logic                   percolates,
    output logic                   stop
);
    import puf_pkg::*;

    // The controller sequences commands; the datapath owns all storage.
    puf_cmd_t cmd;
    puf_sts_t sts;

    puf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // The result register lets a new beat enter while the last waits.
    puf_dpath #(.SIDE(SIDE)) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .site_index   (site_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .newly_opened (newly_opened),
        .open_count   (open_count),
        .percolates   (percolates),
        .stop         (stop)
    );

endmodule
